// ----- rtl/rle_pkg.sv -----
package rle_pkg;

   // Field widths of the sample and of the encoded word
   localparam int SAMPLE_WIDTH = 16;
   localparam int LENGTH_WIDTH = 16;

   // Longest run a single word can carry
   localparam logic [LENGTH_WIDTH-1:0] RUN_MAX = {LENGTH_WIDTH{1'b1}};

   // Default depth of the queue between front and back
   localparam int RLE_QUEUE_DEPTH = 4;

   // One encoded word as it leaves the block
   typedef struct packed {
      logic [LENGTH_WIDTH-1:0] run_length;
      logic [SAMPLE_WIDTH-1:0] run_value;
      logic                    final_word;
   } word_type;

   // Up to two words caused by one input item: the closed run first,
   // then the run flushed by a block end
   typedef struct packed {
      logic     close_valid;
      word_type close_word;
      logic     flush_valid;
      word_type flush_word;
   } pair_type;

endpackage

// ----- rtl/rle_front.sv -----
module rle_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [rle_pkg::SAMPLE_WIDTH-1:0] sample_value,
   input  logic                             block_end,
   output rle_pkg::pair_type                pair,
   output logic                             push,
   output logic                             run_open
);
   import rle_pkg::*;

   logic [SAMPLE_WIDTH-1:0] cur_value_ff, cur_value_in;
   logic [LENGTH_WIDTH-1:0] cur_length_ff, cur_length_in;
   logic                    run_open_ff, run_open_in;
   logic                    extend;
   logic [SAMPLE_WIDTH-1:0] new_value;
   logic [LENGTH_WIDTH-1:0] new_length;

   // Classify the sample against the open run
   always_comb begin
      extend = run_open_ff && (sample_value == cur_value_ff) && (cur_length_ff != RUN_MAX);
      if (extend) begin
         new_value  = cur_value_ff;
         new_length = cur_length_ff + LENGTH_WIDTH'(1);
      end else begin
         new_value  = sample_value;
         new_length = LENGTH_WIDTH'(1);
      end

      // Closed run goes out ahead of any flush
      pair.close_valid            = run_open_ff && !extend;
      pair.close_word.run_length  = cur_length_ff;
      pair.close_word.run_value   = cur_value_ff;
      pair.close_word.final_word  = 1'b0;
      pair.flush_valid            = block_end;
      pair.flush_word.run_length  = new_length;
      pair.flush_word.run_value   = new_value;
      pair.flush_word.final_word  = 1'b1;

      push = accept && (pair.close_valid || pair.flush_valid);

      // Run state update; a block end leaves no run open
      cur_value_in  = cur_value_ff;
      cur_length_in = cur_length_ff;
      run_open_in   = run_open_ff;
      if (accept) begin
         if (block_end) begin
            cur_value_in  = '0;
            cur_length_in = '0;
            run_open_in   = 1'b0;
         end else begin
            cur_value_in  = new_value;
            cur_length_in = new_length;
            run_open_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_value_ff  <= '0;
         cur_length_ff <= '0;
         run_open_ff   <= 1'b0;
      end else begin
         cur_value_ff  <= cur_value_in;
         cur_length_ff <= cur_length_in;
         run_open_ff   <= run_open_in;
      end
   end

   assign run_open = run_open_ff;

endmodule

// ----- rtl/rle_queue.sv -----
module rle_queue #(
   parameter int DEPTH = rle_pkg::RLE_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rle_pkg::pair_type push_data,
   input  logic              pop,
   output rle_pkg::pair_type pop_data,
   output logic              full,
   output logic              empty
);
   import rle_pkg::*;

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   pair_type                mem_ff [DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   function automatic logic [PtrWidth-1:0] next_ptr(input logic [PtrWidth-1:0] ptr);
      next_ptr = (ptr == PtrWidth'(DEPTH - 1)) ? '0 : ptr + PtrWidth'(1);
   endfunction

   // Pointer and fill count update
   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign full     = (count_ff == CountWidth'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

// ----- rtl/rle_back.sv -----
module rle_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   input  rle_pkg::pair_type                q_data,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rle_pkg::LENGTH_WIDTH-1:0] rsp_run_length,
   output logic [rle_pkg::SAMPLE_WIDTH-1:0] rsp_run_value,
   output logic                             rsp_final_word
);
   import rle_pkg::*;

   logic     out_valid_ff, out_valid_in;
   word_type out_word_ff, out_word_in;
   logic     pend_valid_ff, pend_valid_in;
   word_type pend_word_ff, pend_word_in;
   logic     slot_free;

   // Refill the output register from the held second word or the queue
   always_comb begin
      slot_free     = !out_valid_ff || !rsp_stall;
      q_pop         = 1'b0;
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      pend_valid_in = pend_valid_ff;
      pend_word_in  = pend_word_ff;
      if (slot_free) begin
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = pend_word_ff;
            pend_valid_in = 1'b0;
         end else if (!q_empty) begin
            q_pop         = 1'b1;
            out_valid_in  = 1'b1;
            out_word_in   = q_data.close_valid ? q_data.close_word : q_data.flush_word;
            pend_valid_in = q_data.close_valid && q_data.flush_valid;
            pend_word_in  = q_data.flush_word;
         end else begin
            out_valid_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Word payload, no reset needed
   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      pend_word_ff <= pend_word_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_run_length = out_word_ff.run_length;
   assign rsp_run_value  = out_word_ff.run_value;
   assign rsp_final_word = out_word_ff.final_word;

endmodule

// ----- rtl/sample_run_length_encoder.sv -----
// Run-length encoder for 16-channel logic samples. One sample is taken per clock while
// req_stall is low; equal consecutive samples merge into a run, and a run is sent as a
// (length, value) word when a different sample arrives, when a sample arrives after it
// has reached 65535 samples, or when block_end flushes it (that word carries final_word).
// A sample that both closes a run and ends the block gives two words, sent one at a time
// by the output register; the QUEUE_DEPTH-entry queue between the classifying front and
// the output stage absorbs these, so input throughput stays one sample per clock as long
// as the output is not stalled and words stay below one per cycle on average. Each word
// is held in the queue and then the output register. 0xFFFF is an ordinary sample value.
module sample_run_length_encoder #(
   parameter int QUEUE_DEPTH = rle_pkg::RLE_QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rle_pkg::SAMPLE_WIDTH-1:0] req_sample_value,
   input  logic                             req_block_end,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rle_pkg::LENGTH_WIDTH-1:0] rsp_run_length,
   output logic [rle_pkg::SAMPLE_WIDTH-1:0] rsp_run_value,
   output logic                             rsp_final_word
);
   import rle_pkg::*;

   pair_type front_pair;
   pair_type q_data;
   logic     front_push;
   logic     front_run_open;
   logic     q_pop, q_full, q_empty;
   logic     req_accept;

   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   // Front: run tracking and classification
   rle_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .sample_value (req_sample_value),
      .block_end    (req_block_end),
      .pair         (front_pair),
      .push         (front_push),
      .run_open     (front_run_open)
   );

   // Queue between front and back
   rle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_pair),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Back: serializes words into the output register
   rle_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_run_length (rsp_run_length),
      .rsp_run_value  (rsp_run_value),
      .rsp_final_word (rsp_final_word)
   );

   // A word never carries an empty run
   a_nonzero_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_run_length != '0)
      else $error("encoded word with zero run length");

   // A block end always leaves a word in the queue and closes the run
   a_block_end_push: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_block_end) |-> front_push)
      else $error("block end produced no word");

   a_block_end_close: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_block_end) |=> !front_run_open)
      else $error("run still open after block end");

endmodule

// ----- bench/testbench.sv -----
module testbench;
   import rle_pkg::*;

   localparam int STALL_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int RANDOM_SAMPLES = 1450;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] value;
      logic                    last;
   } capture_sample_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [SAMPLE_WIDTH-1:0] req_sample_value = '0;
   logic                    req_block_end = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [LENGTH_WIDTH-1:0] rsp_run_length;
   logic [SAMPLE_WIDTH-1:0] rsp_run_value;
   logic                    rsp_final_word;

   // Samples waiting to be sent, and encoded words still owed by the block
   capture_sample_type pending_samples[$];
   word_type           expected_words[$];

   // Predictor copy of the open run
   logic [SAMPLE_WIDTH-1:0] open_value;
   logic [LENGTH_WIDTH-1:0] open_length;
   logic                    run_is_open;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int samples_sent = 0;
   int words_checked = 0;
   int full_runs = 0;
   int double_word_samples = 0;
   int quiet_cycles = 0;
   logic [SAMPLE_WIDTH-1:0] last_picked = '0;

   sample_run_length_encoder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_value (req_sample_value),
      .req_block_end    (req_block_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_run_length   (rsp_run_length),
      .rsp_run_value    (rsp_run_value),
      .rsp_final_word   (rsp_final_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
      error_count++;
   endtask

   // Run-length prediction for one accepted sample; pushes 0, 1 or 2 words
   function automatic void encode_sample(input logic [SAMPLE_WIDTH-1:0] sample,
                                         input logic last);
      word_type w;
      int       made;
      made = 0;
      if (run_is_open && sample == open_value && open_length != RUN_MAX) begin
         open_length = open_length + 1'b1;
      end else begin
         if (run_is_open) begin
            w.run_length = open_length;
            w.run_value  = open_value;
            w.final_word = 1'b0;
            expected_words.push_back(w);
            made++;
            if (open_length == RUN_MAX) full_runs++;
         end
         open_value  = sample;
         open_length = LENGTH_WIDTH'(1);
         run_is_open = 1'b1;
      end
      if (last) begin
         w.run_length = open_length;
         w.run_value  = open_value;
         w.final_word = 1'b1;
         expected_words.push_back(w);
         made++;
         if (open_length == RUN_MAX) full_runs++;
         open_value  = '0;
         open_length = '0;
         run_is_open = 1'b0;
      end
      if (made == 2) double_word_samples++;
   endfunction

   // Driver: presents queued samples, holds a stalled transaction steady
   always @(posedge clock) begin
      capture_sample_type nxt;
      logic               taken;
      if (reset) begin
         req_valid <= 1'b0;
         open_value  = '0;
         open_length = '0;
         run_is_open = 1'b0;
      end else begin
         taken = req_valid && !req_stall;
         if (taken) begin
            encode_sample(req_sample_value, req_block_end);
            samples_sent++;
         end
         if (!req_valid || taken) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_samples.pop_front();
               req_valid        <= 1'b1;
               req_sample_value <= nxt.value;
               req_block_end    <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Monitor: each accepted word against the oldest expectation
   always @(posedge clock) begin
      word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word, run_length", rsp_run_length, 0);
         end else begin
            w = expected_words.pop_front();
            if (rsp_run_length !== w.run_length)
               report_mismatch("run_length", rsp_run_length, w.run_length);
            if (rsp_run_value !== w.run_value)
               report_mismatch("run_value", rsp_run_value, w.run_value);
            if (rsp_final_word !== w.final_word)
               report_mismatch("final_word", rsp_final_word, w.final_word);
            words_checked++;
         end
      end
   end

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("sample_run_length_encoder regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_sample(input logic [SAMPLE_WIDTH-1:0] value, input logic last);
      capture_sample_type s;
      s.value = value;
      s.last  = last;
      pending_samples.push_back(s);
   endtask

   task automatic queue_run(input logic [SAMPLE_WIDTH-1:0] value, input int count,
                            input logic last_at_end);
      for (int i = 0; i < count; i++) queue_sample(value, last_at_end && i == count - 1);
   endtask

   // Hold off until the queue is sent and every owed word has come back
   task automatic drain;
      @(negedge clock);
      while (pending_samples.size() > 0 || req_valid || expected_words.size() > 0)
         @(negedge clock);
   endtask

   // Sample values biased toward corners and repeats
   function automatic logic [SAMPLE_WIDTH-1:0] pick_value();
      logic [SAMPLE_WIDTH-1:0] v;
      case ($urandom_range(7))
         0: v = '0;
         1: v = '1;
         2: v = 16'(1) << $urandom_range(15);
         3: v = ~(16'(1) << $urandom_range(15));
         4: v = last_picked;
         default: v = 16'($urandom);
      endcase
      last_picked = v;
      return v;
   endfunction

   // Mostly well-formed capture blocks of short runs, some stray samples
   task automatic queue_random(input int count);
      int made;
      int nruns;
      int len;
      logic [SAMPLE_WIDTH-1:0] v;
      made = 0;
      while (made < count) begin
         if ($urandom_range(9) == 0) begin
            queue_sample(16'($urandom), $urandom_range(3) == 0);
            made++;
         end else begin
            nruns = $urandom_range(1, 6);
            for (int r = 0; r < nruns; r++) begin
               v   = pick_value();
               len = ($urandom_range(4) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
               queue_run(v, len, r == nruns - 1 && $urandom_range(4) != 0);
               made += len;
            end
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Phase 1: sender idles often, receiver idles more
      send_idle_pct = 31;
      recv_idle_pct = 66;
      queue_sample(16'h0000, 1'b0);       // zero value starts a run straight out of reset
      queue_sample(16'h0000, 1'b0);
      queue_sample(16'h0000, 1'b1);
      queue_sample(16'hFFFF, 1'b1);       // all-ones single-sample block
      queue_run(16'hFFFF, 3, 1'b0);
      queue_sample(16'h0000, 1'b1);       // closes a run and flushes: two words
      queue_sample(16'hAAAA, 1'b0);
      queue_sample(16'h5555, 1'b0);
      queue_sample(16'hAAAA, 1'b0);
      queue_sample(16'h5555, 1'b1);
      queue_sample(16'h8000, 1'b0);
      queue_sample(16'h0001, 1'b0);
      queue_sample(16'h0001, 1'b1);
      queue_sample(16'h0000, 1'b0);       // fresh run right after a flush
      queue_sample(16'h7FFF, 1'b1);
      drain();
      queue_random(RANDOM_SAMPLES / 3);
      drain();

      // Phase 2: roles swapped
      send_idle_pct = 66;
      recv_idle_pct = 31;
      queue_random(RANDOM_SAMPLES / 3);
      drain();

      // Phase 3: full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(RANDOM_SAMPLES / 6);
      queue_random(RANDOM_SAMPLES / 6);
      drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_words.size() != 0)
         report_mismatch("words never delivered", 0, expected_words.size());
      $display("covered %0d samples and %0d encoded words across three back-pressure mixes",
               samples_sent, words_checked);
      $display("%0d full-length runs, %0d samples that produced two words",
               full_runs, double_word_samples);
      if (error_count == 0) begin
         $display("sample_run_length_encoder regression: pass");
      end else begin
         $display("sample_run_length_encoder regression: fail");
      end
      $finish;
   end

endmodule
